>>> hdl/quaternion_vector_rotation_macros.svh
// Assertion macros for the quaternion rotation block.
// No dependencies.
`ifndef QUATERNION_VECTOR_ROTATION_MACROS_SVH
`define QUATERNION_VECTOR_ROTATION_MACROS_SVH
// property holds on every clock edge outside reset
`define QVR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// check in reset too
`define QVR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

>>> hdl/qvr_pkg.sv
// Shared constants for the quaternion rotation block.
// No dependencies.
package qvr_pkg;
  typedef enum logic [1:0] {
    REG_W = 2'd0,
    REG_X = 2'd1,
    REG_Y = 2'd2,
    REG_Z = 2'd3
  } reg_idx_e;
  localparam int unsigned CFG_IDX_BITS = 2;
endpackage

>>> hdl/qvr_divider.sv
// Pipelined restoring divider: one quotient bit per stage, round and saturate.
// Depends on nothing but parameters.
module qvr_divider #(
  parameter int unsigned NUM_BITS = 88,
  parameter int unsigned DEN_BITS = 34,
  parameter int unsigned VEC_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [NUM_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0]        den_i,
  output logic                       valid_o,
  output logic signed [VEC_BITS-1:0] quo_o
);
  localparam int unsigned QB = NUM_BITS;
  localparam int unsigned RB = DEN_BITS + 1;

  logic [QB:0]           vld_q;
  logic [QB-1:0]         n_q   [QB+1];
  logic [RB-1:0]         r_q   [QB+1];
  logic [DEN_BITS-1:0]   dn_q  [QB+1];
  logic                  ng_q  [QB+1];
  logic signed [VEC_BITS-1:0] out_q;
  logic                  ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ov_q  <= 1'b0;
    end else if (en_i) begin
      vld_q <= {vld_q[QB-1:0], valid_i};
      ov_q  <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ng_q[0] <= num_i[NUM_BITS-1];
      n_q[0]  <= num_i[NUM_BITS-1] ? QB'(-num_i) : QB'(num_i);
      r_q[0]  <= '0;
      dn_q[0] <= den_i;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [RB-1:0] rs;
    logic [RB:0]   df;
    always_comb begin
      rs = {r_q[s][RB-2:0], n_q[s][QB-1]};
      df = {1'b0, rs} - {2'b0, dn_q[s]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ng_q[s+1] <= ng_q[s];
        dn_q[s+1] <= dn_q[s];
        r_q[s+1]  <= df[RB] ? rs : df[RB-1:0];
        n_q[s+1]  <= {n_q[s][QB-2:0], ~df[RB]};
      end
    end
  end

  logic [QB:0]   qr;
  logic [RB:0]   r2;
  logic [QB:0]   lim;
  logic [QB:0]   mag;
  always_comb begin
    r2  = {r_q[QB], 1'b0};
    qr  = {1'b0, n_q[QB]} + ((r2 >= {2'b0, dn_q[QB]}) ? (QB+1)'(1) : '0);
    lim = (QB+1)'(1) << (VEC_BITS - 1);
    if (ng_q[QB]) mag = (qr > lim) ? lim : qr;
    else          mag = (qr > lim - 1) ? lim - 1 : qr;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) out_q <= ng_q[QB] ? VEC_BITS'(-mag) : VEC_BITS'(mag);
  end

  assign valid_o = ov_q;
  assign quo_o   = out_q;
endmodule

>>> hdl/qvr_product.sv
// Product stages: conj(q)*(0,v), then *q, plus the squared norm.
// Depends on nothing but parameters.
module qvr_product #(
  parameter int unsigned VEC_BITS  = 32,
  parameter int unsigned QUAT_BITS = 16,
  parameter int unsigned NUM_BITS  = 88,
  parameter int unsigned DEN_BITS  = 34
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [QUAT_BITS-1:0] qw_i,
  input  logic signed [QUAT_BITS-1:0] qx_i,
  input  logic signed [QUAT_BITS-1:0] qy_i,
  input  logic signed [QUAT_BITS-1:0] qz_i,
  input  logic signed [VEC_BITS-1:0]  vx_i,
  input  logic signed [VEC_BITS-1:0]  vy_i,
  input  logic signed [VEC_BITS-1:0]  vz_i,
  output logic                        valid_o,
  output logic signed [NUM_BITS-1:0]  rx_o,
  output logic signed [NUM_BITS-1:0]  ry_o,
  output logic signed [NUM_BITS-1:0]  rz_o,
  output logic [DEN_BITS-1:0]         den_o
);
  localparam int unsigned PB = VEC_BITS + QUAT_BITS;
  localparam int unsigned SB = PB + 2;

  logic [3:0] vld_q;
  logic signed [QUAT_BITS-1:0] w1_q, x1_q, y1_q, z1_q, w2_q, x2_q, y2_q, z2_q;
  logic signed [PB-1:0] wx_q, wy_q, wz_q, xx_q, xy_q, xz_q;
  logic signed [PB-1:0] yx_q, yy_q, yz_q, zx_q, zy_q, zz_q;
  logic signed [SB-1:0] s_q, a_q, b_q, c_q;
  logic signed [NUM_BITS-1:0] p_q [12];
  logic signed [NUM_BITS-1:0] rx_q, ry_q, rz_q;
  logic [DEN_BITS-1:0] d1_q, d2_q, d3_q, d4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en_i) vld_q <= {vld_q[2:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q <= PB'(qw_i * vx_i); wy_q <= PB'(qw_i * vy_i); wz_q <= PB'(qw_i * vz_i);
      xx_q <= PB'(qx_i * vx_i); xy_q <= PB'(qx_i * vy_i); xz_q <= PB'(qx_i * vz_i);
      yx_q <= PB'(qy_i * vx_i); yy_q <= PB'(qy_i * vy_i); yz_q <= PB'(qy_i * vz_i);
      zx_q <= PB'(qz_i * vx_i); zy_q <= PB'(qz_i * vy_i); zz_q <= PB'(qz_i * vz_i);
      w1_q <= qw_i; x1_q <= qx_i; y1_q <= qy_i; z1_q <= qz_i;
      d1_q <= DEN_BITS'(qw_i * qw_i) + DEN_BITS'(qx_i * qx_i)
            + DEN_BITS'(qy_i * qy_i) + DEN_BITS'(qz_i * qz_i);
      // stage 2: conj(q)*(0,v)
      s_q <= SB'(xx_q) + SB'(yy_q) + SB'(zz_q);
      a_q <= SB'(wx_q) - SB'(yz_q) + SB'(zy_q);
      b_q <= SB'(wy_q) - SB'(zx_q) + SB'(xz_q);
      c_q <= SB'(wz_q) - SB'(xy_q) + SB'(yx_q);
      w2_q <= w1_q; x2_q <= x1_q; y2_q <= y1_q; z2_q <= z1_q;
      d2_q <= d1_q;
      // stage 3: products with q
      p_q[0]  <= NUM_BITS'(s_q * x2_q); p_q[1]  <= NUM_BITS'(a_q * w2_q);
      p_q[2]  <= NUM_BITS'(b_q * z2_q); p_q[3]  <= NUM_BITS'(c_q * y2_q);
      p_q[4]  <= NUM_BITS'(s_q * y2_q); p_q[5]  <= NUM_BITS'(b_q * w2_q);
      p_q[6]  <= NUM_BITS'(c_q * x2_q); p_q[7]  <= NUM_BITS'(a_q * z2_q);
      p_q[8]  <= NUM_BITS'(s_q * z2_q); p_q[9]  <= NUM_BITS'(c_q * w2_q);
      p_q[10] <= NUM_BITS'(a_q * y2_q); p_q[11] <= NUM_BITS'(b_q * x2_q);
      d3_q <= d2_q;
      // stage 4: sums
      rx_q <= p_q[0] + p_q[1] + p_q[2] - p_q[3];
      ry_q <= p_q[4] + p_q[5] + p_q[6] - p_q[7];
      rz_q <= p_q[8] + p_q[9] + p_q[10] - p_q[11];
      d4_q <= d3_q;
    end
  end

  assign valid_o = vld_q[3];
  assign rx_o    = rx_q;
  assign ry_o    = ry_q;
  assign rz_o    = rz_q;
  assign den_o   = d4_q;
endmodule

>>> hdl/quaternion_vector_rotation.sv
// Channel  Dir  Fields (tdata, lowest bit up)
// s_axis   in   vec_x, vec_y, vec_z
// m_axis   out  rot_x, rot_y, rot_z
// cfg      in   quat_w, quat_x, quat_y, quat_z by index
// One transfer per cycle unless m_axis stalls; 4 product + NUM_BITS+2 divider stages.
// Depth is set by the bit-per-stage restoring dividers.
// Stall of m_axis freezes the whole pipeline; s_axis_tready follows the output stage.
// Reset clears valid bits and loads the quaternion with 1.0.
// Top level; uses qvr_pkg, qvr_product, qvr_divider and the macro header.
`include "quaternion_vector_rotation_macros.svh"
module quaternion_vector_rotation #(
  parameter int unsigned VEC_BITS  = 32,
  parameter int unsigned QUAT_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [3*VEC_BITS-1:0]   s_axis_tdata,   // vec_x, vec_y, vec_z
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [3*VEC_BITS-1:0]   m_axis_tdata,   // rot_x, rot_y, rot_z
  input  logic                    cfg_we_i,
  input  logic [qvr_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [QUAT_BITS-1:0]    cfg_data_i
);
  localparam int unsigned DEN_BITS = 2*QUAT_BITS + 2;
  localparam int unsigned NUM_BITS = VEC_BITS + 3*QUAT_BITS + 6;

  logic signed [QUAT_BITS-1:0] qw_q, qx_q, qy_q, qz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qw_q <= QUAT_BITS'(1) << (QUAT_BITS - 2);
      qx_q <= '0; qy_q <= '0; qz_q <= '0;
    end else if (cfg_we_i) begin
      unique case (qvr_pkg::reg_idx_e'(cfg_idx_i))
        qvr_pkg::REG_W: qw_q <= cfg_data_i;
        qvr_pkg::REG_X: qx_q <= cfg_data_i;
        qvr_pkg::REG_Y: qy_q <= cfg_data_i;
        qvr_pkg::REG_Z: qz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic pv;
  logic signed [NUM_BITS-1:0] rx, ry, rz;
  logic [DEN_BITS-1:0] den;

  qvr_product #(.VEC_BITS(VEC_BITS), .QUAT_BITS(QUAT_BITS),
                .NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS)) u_prod (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid),
    .qw_i(qw_q), .qx_i(qx_q), .qy_i(qy_q), .qz_i(qz_q),
    .vx_i(s_axis_tdata[VEC_BITS-1:0]),
    .vy_i(s_axis_tdata[2*VEC_BITS-1:VEC_BITS]),
    .vz_i(s_axis_tdata[3*VEC_BITS-1:2*VEC_BITS]),
    .valid_o(pv), .rx_o(rx), .ry_o(ry), .rz_o(rz), .den_o(den)
  );

  // zero norm: divide zero by one
  logic [DEN_BITS-1:0] dd;
  logic                dz;
  assign dz = (den == '0);
  assign dd = dz ? DEN_BITS'(1) : den;

  logic [2:0] dv;
  logic signed [VEC_BITS-1:0] ox, oy, oz;
  qvr_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS), .VEC_BITS(VEC_BITS)) u_dx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pv), .num_i(dz ? '0 : rx), .den_i(dd),
    .valid_o(dv[0]), .quo_o(ox));
  qvr_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS), .VEC_BITS(VEC_BITS)) u_dy (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pv), .num_i(dz ? '0 : ry), .den_i(dd),
    .valid_o(dv[1]), .quo_o(oy));
  qvr_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS), .VEC_BITS(VEC_BITS)) u_dz (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pv), .num_i(dz ? '0 : rz), .den_i(dd),
    .valid_o(dv[2]), .quo_o(oz));

  assign m_axis_tvalid = dv[0];
  assign m_axis_tdata  = {oz, oy, ox};

  `QVR_ASSERT(a_lanes_agree, dv[0] == dv[1] && dv[1] == dv[2], "divider lanes out of step")
  `QVR_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "output changed under stall")
  `QVR_ASSERT_RST(a_ready, !rst_ni || s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready wrong")
endmodule

>>> bench/quaternion_vector_rotation_tb.sv
// Self-checking bench for quaternion_vector_rotation: streams Q16.16 vectors
// under several quaternion settings and idle patterns, predicts each rotation.
// Depends on qvr_pkg and the quaternion_vector_rotation RTL.
`timescale 1ns / 1ps
module quaternion_vector_rotation_tb;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } vec3_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [95:0]       s_axis_tdata = '0;   // vec_x, vec_y, vec_z
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [95:0]       m_axis_tdata;        // rot_x, rot_y, rot_z
  logic              cfg_we_i = 1'b0;
  qvr_pkg::reg_idx_e cfg_idx_i = qvr_pkg::REG_W;
  logic [15:0]       cfg_data_i = '0;

  quaternion_vector_rotation dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  vec3_t             vec_queue[$];
  vec3_t             rot_expected[$];
  logic signed [15:0] quat_w = 16'sd16384, quat_x = '0, quat_y = '0, quat_z = '0;
  int unsigned       send_idle_pct = 0, recv_stall_pct = 0;
  int                errors = 0;

  function automatic logic [31:0] div_round_sat(logic signed [127:0] num,
                                                logic [127:0] den);
    logic [127:0] mag, quo, rem;
    logic         negative;
    negative = num < 0;
    mag = negative ? -num : num;
    quo = mag / den;
    rem = mag - quo * den;
    if ((rem << 1) >= den) quo = quo + 1;
    if (negative) begin
      if (quo > 128'h8000_0000) quo = 128'h8000_0000;
      return 32'(-quo);
    end
    if (quo > 128'h7FFF_FFFF) quo = 128'h7FFF_FFFF;
    return quo[31:0];
  endfunction

  // vector part of conj(q)*(0,v)*q, divided by |q|^2
  function automatic vec3_t rotate_by_inverse(vec3_t v);
    logic signed [127:0] w, x, y, z, vx, vy, vz, den, s, a, b, c, rx, ry, rz;
    vec3_t r;
    w = quat_w; x = quat_x; y = quat_y; z = quat_z;
    vx = v.x; vy = v.y; vz = v.z;
    den = w*w + x*x + y*y + z*z;
    if (den == 0) return '0;
    s = x*vx + y*vy + z*vz;
    a = w*vx - (y*vz - z*vy);
    b = w*vy - (z*vx - x*vz);
    c = w*vz - (x*vy - y*vx);
    rx = s*x + a*w + b*z - c*y;
    ry = s*y + b*w + c*x - a*z;
    rz = s*z + c*w + a*y - b*x;
    r.x = div_round_sat(rx, den);
    r.y = div_round_sat(ry, den);
    r.z = div_round_sat(rz, den);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t rotation %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (vec_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= vec_queue.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    vec3_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        rot_expected.push_back(rotate_by_inverse(vec3_t'(s_axis_tdata)));
      if (m_axis_tvalid && m_axis_tready) begin
        got = vec3_t'(m_axis_tdata);
        if (rot_expected.size() == 0) begin
          report_mismatch("unexpected transfer x", got.x, 32'h0);
        end else begin
          want = rot_expected.pop_front();
          if (got.x !== want.x) report_mismatch("x", got.x, want.x);
          if (got.y !== want.y) report_mismatch("y", got.y, want.y);
          if (got.z !== want.z) report_mismatch("z", got.z, want.z);
        end
      end
    end
  end

  task automatic write_reg(qvr_pkg::reg_idx_e idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      qvr_pkg::REG_W: quat_w = value;
      qvr_pkg::REG_X: quat_x = value;
      qvr_pkg::REG_Y: quat_y = value;
      default: quat_z = value;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    write_reg(qvr_pkg::REG_W, w);
    write_reg(qvr_pkg::REG_X, x);
    write_reg(qvr_pkg::REG_Y, y);
    write_reg(qvr_pkg::REG_Z, z);
  endtask

  task automatic drain();
    while (vec_queue.size() > 0 || s_axis_tvalid || rot_expected.size() > 0)
      @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_component();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_random(int n);
    vec3_t v;
    repeat (n) begin
      v.x = rand_component();
      v.y = rand_component();
      v.z = rand_component();
      vec_queue.push_back(v);
    end
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
      default: begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
  endtask

  initial begin
    vec3_t v;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: reset quaternion, field extremes
    v = '{32'sd0, 32'sd0, 32'sd0};                   vec_queue.push_back(v);
    v = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}; vec_queue.push_back(v);
    v = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}; vec_queue.push_back(v);
    v = '{32'sd65536, -32'sd65536, 32'sd1};          vec_queue.push_back(v);
    drain();
    // zero quaternion gives zero output
    set_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd12345};     vec_queue.push_back(v);
    drain();
    // extreme registers: overflow and saturation, unnormalised direction
    set_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF}; vec_queue.push_back(v);
    v = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}; vec_queue.push_back(v);
    drain();
    set_quat(16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000);
    v = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000}; vec_queue.push_back(v);
    v = '{32'sd65536, 32'sd0, 32'sd0};               vec_queue.push_back(v);
    drain();
    // 90 degrees about x, then nearly 180 degrees about z
    set_quat(16'd11585, 16'd11585, 16'd0, 16'd0);
    v = '{32'sd65536, 32'sd131072, 32'sd196608};     vec_queue.push_back(v);
    drain();
    set_quat(16'd1, 16'd0, 16'd0, 16'h7FFF);
    v = '{32'sd65536, 32'sd131072, 32'sd196608};     vec_queue.push_back(v);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      set_idling(phase);
      case (phase)
        0: set_quat(16'd16384, 16'd0, 16'd0, 16'd0);
        1: set_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        2: set_quat(16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF);
        3: set_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        default: set_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      push_random(phase == 3 ? 60 : 210);
      drain();
    end
    repeat (200) @(posedge clk_i);
    if (errors == 0 && rot_expected.size() == 0)
      $display("quaternion_vector_rotation: match");
    else
      $display("quaternion_vector_rotation: mismatch");
    $finish;
  end

  initial begin
    #5ms;
    $display("quaternion_vector_rotation: mismatch");
    $finish;
  end
endmodule

>>> sim.f
+incdir+hdl
hdl/qvr_pkg.sv
hdl/qvr_divider.sv
hdl/qvr_product.sv
hdl/quaternion_vector_rotation.sv
bench/quaternion_vector_rotation_tb.sv
